### hw/rtl/fca_pkg.sv
// ============================================================================
// fca_pkg
// Shared types, constants and the arctangent table of the full-circle
// angle core.
// ============================================================================
package fca_pkg;

    localparam int CW = 64;
    localparam int ZW = 32;
    localparam int OW = 24;

    localparam logic [1:0] UNIT_TURNS = 2'd0;
    localparam logic [1:0] UNIT_RAD   = 2'd1;
    localparam logic [1:0] UNIT_DEG   = 2'd2;

    localparam logic [ZW-1:0] Z_ZERO    = 32'h0000_0000;
    localparam logic [ZW-1:0] Z_QUARTER = 32'h4000_0000;
    localparam logic [ZW-1:0] Z_HALF    = 32'h8000_0000;
    localparam logic [ZW-1:0] Z_THREEQ  = 32'hC000_0000;

    localparam logic [ZW-1:0] K_TWO_PI = 32'hC90F_DAA2;
    localparam logic [ZW-1:0] K_DEG    = 32'd360;
    localparam logic [ZW-1:0] K_TURNS  = 32'd1;

    localparam logic [24:0] RAD_FULL = 25'd13176795;
    localparam logic [24:0] DEG_FULL = 25'd11796480;

    localparam logic [ZW-1:0] C_ARC [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic                 valid;
        logic                 bypass;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ZW-1:0]        z;
    } t_cell_data;

endpackage

### hw/rtl/fca_if.sv
// ============================================================================
// fca_if
// Valid/ready channels carrying sample pairs in and angles out.
// ============================================================================
interface fca_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] y_sample;
    logic signed [SAMPLE_BITS-1:0] x_sample;

    modport source (output valid, output y_sample, output x_sample, input ready);
    modport sink   (input valid, input y_sample, input x_sample, output ready);
endinterface

interface fca_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] angle_out;

    modport source (output valid, output angle_out, input ready);
    modport sink   (input valid, input angle_out, output ready);
endinterface

### hw/rtl/full_circle_atan2_angle_core.sv
// An accepted transaction is registered at entry, in every cell and in both unit-conversion stages before its result.
// Throughput: one transaction per cycle while the output is not stalled; the entry stage, one cell per
// micro-rotation and the two-stage unit conversion all advance together.
// The whole pipeline holds while the output register is full and not taken.
// Reset (synchronous, active low) empties the pipeline and sets the unit to turns.
// ============================================================================
// full_circle_atan2_angle_core
// Four-quadrant angle of a sample pair over the full circle, from a pipelined
// CORDIC in vectoring mode, given in turns, radians or degrees.
// ============================================================================
module full_circle_atan2_angle_core #(
    parameter int SAMPLE_BITS    = 24,
    parameter int ROTATION_STEPS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [1:0]    i_cfg_wr_data,
    fca_in_if.sink        i_in,
    fca_out_if.source     o_out
);
    import fca_pkg::*;

    localparam int PRE_SHIFT = 60 - SAMPLE_BITS;

    logic [1:0] r_mode;
    logic       w_en;

    logic signed [CW-1:0] w_y;
    logic signed [CW-1:0] w_x;
    t_cell_data           n_entry;
    t_cell_data           r_entry;
    t_cell_data           w_chain [ROTATION_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= UNIT_TURNS;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    assign w_y = {{(CW-SAMPLE_BITS){i_in.y_sample[SAMPLE_BITS-1]}}, i_in.y_sample};
    assign w_x = {{(CW-SAMPLE_BITS){i_in.x_sample[SAMPLE_BITS-1]}}, i_in.x_sample};

    always_comb begin
        n_entry.valid  = i_in.valid;
        n_entry.bypass = 1'b0;
        n_entry.x      = w_x <<< PRE_SHIFT;
        n_entry.y      = w_y <<< PRE_SHIFT;
        n_entry.z      = Z_ZERO;
        if (w_y == '0) begin
            n_entry.bypass = 1'b1;
            n_entry.z      = w_x[CW-1] ? Z_HALF : Z_ZERO;
        end else if (w_x == '0) begin
            n_entry.bypass = 1'b1;
            n_entry.z      = w_y[CW-1] ? Z_THREEQ : Z_QUARTER;
        end else if (w_x[CW-1]) begin
            n_entry.x = (-w_x) <<< PRE_SHIFT;
            n_entry.y = (-w_y) <<< PRE_SHIFT;
            n_entry.z = Z_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else if (w_en) begin
            r_entry.valid <= n_entry.valid;
        end
        if (w_en) begin
            r_entry.bypass <= n_entry.bypass;
            r_entry.x      <= n_entry.x;
            r_entry.y      <= n_entry.y;
            r_entry.z      <= n_entry.z;
        end
    end

    assign w_chain[0] = r_entry;

    for (genvar g = 0; g < ROTATION_STEPS; g++) begin : g_cell
        fca_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_d     (w_chain[g]),
            .o_d     (w_chain[g+1])
        );
    end

    fca_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_mode  (r_mode),
        .i_valid (w_chain[ROTATION_STEPS].valid),
        .i_z     (w_chain[ROTATION_STEPS].z),
        .o_valid (o_out.valid),
        .o_angle (o_out.angle_out)
    );

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |-> !i_in.ready)
        else $error("input taken while pipeline is stalled");

    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && r_mode == UNIT_DEG && $stable(r_mode)
            |-> {1'b0, o_out.angle_out} < DEG_FULL)
        else $error("degree angle reached the full circle");
endmodule

### hw/rtl/fca_cell.sv
// ============================================================================
// fca_cell
// One vectoring micro-rotation of the angle pipeline.
// ============================================================================
module fca_cell #(
    parameter int STEP = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  fca_pkg::t_cell_data i_d,
    output fca_pkg::t_cell_data o_d
);
    import fca_pkg::*;

    localparam logic [ZW-1:0] ARC = C_ARC[5'(STEP % 32)];

    t_cell_data r_d;
    t_cell_data n_d;
    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;

    assign w_dx = i_d.y >>> STEP;
    assign w_dy = i_d.x >>> STEP;

    always_comb begin
        n_d = i_d;
        if (!i_d.bypass) begin
            if (!i_d.y[CW-1]) begin
                n_d.x = i_d.x + w_dx;
                n_d.y = i_d.y - w_dy;
                n_d.z = i_d.z + ARC;
            end else begin
                n_d.x = i_d.x - w_dx;
                n_d.y = i_d.y + w_dy;
                n_d.z = i_d.z - ARC;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d.valid <= i_d.valid;
        end
        if (i_en) begin
            r_d.bypass <= n_d.bypass;
            r_d.x      <= n_d.x;
            r_d.y      <= n_d.y;
            r_d.z      <= n_d.z;
        end
    end

    assign o_d = r_d;
endmodule

### hw/rtl/fca_scale.sv
// ============================================================================
// fca_scale
// Converts the angle in turns to the selected output unit with rounding, wrapping a full circle to zero.
// ============================================================================
module fca_scale (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [1:0]             i_mode,
    input  logic                   i_valid,
    input  logic [fca_pkg::ZW-1:0] i_z,
    output logic                   o_valid,
    output logic [fca_pkg::OW-1:0] o_angle
);
    import fca_pkg::*;

    logic [ZW-1:0]   w_k;
    logic [2*ZW-1:0] r_prod;
    logic [1:0]      r_mode;
    logic            r_v1;
    logic [2*ZW:0]   w_sum;
    logic [24:0]     w_round;
    logic [OW-1:0]   n_angle;
    logic [OW-1:0]   r_angle;
    logic            r_v2;

    always_comb begin
        unique case (i_mode)
            UNIT_RAD: w_k = K_TWO_PI;
            UNIT_DEG: w_k = K_DEG;
            default:  w_k = K_TURNS;
        endcase
    end

    always_comb begin
        unique case (r_mode)
            UNIT_RAD: begin
                w_sum   = {1'b0, r_prod} + (65'd1 << 39);
                w_round = w_sum[64:40];
                n_angle = (w_round >= RAD_FULL) ? '0 : w_round[OW-1:0];
            end
            UNIT_DEG: begin
                w_sum   = {1'b0, r_prod} + (65'd1 << 16);
                w_round = w_sum[41:17];
                n_angle = (w_round >= DEG_FULL) ? '0 : w_round[OW-1:0];
            end
            default: begin
                w_sum   = {1'b0, r_prod} + 65'd128;
                w_round = w_sum[32:8];
                n_angle = w_round[OW-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_prod  <= i_z * w_k;
            r_mode  <= i_mode;
            r_angle <= n_angle;
        end
    end

    assign o_valid = r_v2;
    assign o_angle = r_angle;
endmodule

### test/full_circle_atan2_angle_core_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// full_circle_atan2_angle_core_tb
// Self-checking bench for the full-circle angle core. Sample pairs go in
// through the input channel under random source gaps and sink stalls. Each
// accepted pair is run through a bit-exact CORDIC vectoring model here, and
// the angle it gives in the current unit is checked against what comes out.
// The unit register is rewritten between phases while the core is idle.
// ============================================================================
module full_circle_atan2_angle_core_tb;

    import fca_pkg::*;

    localparam int          SAMPLE_W    = 24;
    localparam int          ROT_STEPS   = 24;
    localparam int          CORE_DELAY  = ROT_STEPS + 3;
    localparam int          NUM_PHASES  = 8;
    localparam int          PHASE_ITEMS = 112;
    localparam logic [1:0]  UNIT_SPARE  = 2'd3;

    localparam logic [31:0] ANG_ZERO    = 32'h0000_0000;
    localparam logic [31:0] ANG_QUARTER = 32'h4000_0000;
    localparam logic [31:0] ANG_HALF    = 32'h8000_0000;
    localparam logic [31:0] ANG_THREEQ  = 32'hC000_0000;

    localparam logic [63:0] RAD_SCALE   = 64'd3373259426;
    localparam logic [63:0] RAD_LIMIT   = 64'd13176795;
    localparam logic [63:0] DEG_SCALE   = 64'd360;
    localparam logic [63:0] DEG_LIMIT   = 64'd11796480;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = -24'sh800000;

    localparam logic [31:0] ARC_STEP [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct {
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] x;
    } sample_pair_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] x;
        logic [1:0]                 unit;
        logic [23:0]                angle;
    } angle_expect_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [1:0] i_cfg_wr_data;

    fca_in_if #(.SAMPLE_BITS(SAMPLE_W)) in_ch ();
    fca_out_if out_ch ();

    full_circle_atan2_angle_core #(
        .SAMPLE_BITS    (SAMPLE_W),
        .ROTATION_STEPS (ROT_STEPS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    sample_pair_t  pair_q[$];
    angle_expect_t expected_angles[$];
    logic [1:0]    unit_sel;
    logic          idle_on;
    int            src_gap;
    int            snk_gap;
    int            n_errors;
    int            n_checked;
    int            n_phases_done;

    function automatic logic [31:0] cordic_turns(logic signed [SAMPLE_W-1:0] ys,
                                                 logic signed [SAMPLE_W-1:0] xs);
        logic signed [63:0] xv;
        logic signed [63:0] yv;
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [31:0]        z;
        z = ANG_ZERO;
        if (ys == 0) begin
            return (xs < 0) ? ANG_HALF : ANG_ZERO;
        end
        if (xs == 0) begin
            return (ys > 0) ? ANG_QUARTER : ANG_THREEQ;
        end
        xv = xs;
        yv = ys;
        if (xs < 0) begin
            xv = -xv;
            yv = -yv;
            z  = ANG_HALF;
        end
        xv = xv <<< (60 - SAMPLE_W);
        yv = yv <<< (60 - SAMPLE_W);
        for (int i = 0; i < ROT_STEPS && i < 32; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv >= 0) begin
                xv = xv + dx;
                yv = yv - dy;
                z  = z + ARC_STEP[i];
            end else begin
                xv = xv - dx;
                yv = yv + dy;
                z  = z - ARC_STEP[i];
            end
        end
        return z;
    endfunction

    function automatic logic [23:0] predict_angle(logic signed [SAMPLE_W-1:0] ys,
                                                  logic signed [SAMPLE_W-1:0] xs,
                                                  logic [1:0] unit);
        logic [31:0] z;
        logic [63:0] wide;
        logic [32:0] rounded;
        z = cordic_turns(ys, xs);
        case (unit)
            UNIT_RAD: begin
                wide = ({32'd0, z} * RAD_SCALE + (64'd1 << 39)) >> 40;
                if (wide >= RAD_LIMIT) begin
                    wide = 64'd0;
                end
                return wide[23:0];
            end
            UNIT_DEG: begin
                wide = ({32'd0, z} * DEG_SCALE + (64'd1 << 16)) >> 17;
                if (wide >= DEG_LIMIT) begin
                    wide = 64'd0;
                end
                return wide[23:0];
            end
            default: begin
                rounded = {1'b0, z} + 33'd128;
                return rounded[31:8];
            end
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] corner_value();
        case ($urandom_range(0, 4))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return -24'sd1;
            3:       return 24'sd1;
            default: return 24'sd0;
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] tiny_value();
        return $signed(24'($urandom_range(0, 8))) - 24'sd4;
    endfunction

    function automatic sample_pair_t random_pair();
        sample_pair_t p;
        int           pick;
        pick = $urandom_range(0, 99);
        p.y = 24'($urandom);
        p.x = 24'($urandom);
        if (pick < 10) begin
            p.y = tiny_value();
            p.x = tiny_value();
        end else if (pick < 20) begin
            if ($urandom_range(0, 1)) p.y = 24'sd0;
            else p.x = 24'sd0;
        end else if (pick < 30) begin
            if ($urandom_range(0, 1)) p.y = tiny_value();
            else p.x = tiny_value();
        end else if (pick < 40) begin
            p.y = corner_value();
            p.x = corner_value();
        end
        return p;
    endfunction

    function automatic sample_pair_t make_pair(logic signed [SAMPLE_W-1:0] ys,
                                               logic signed [SAMPLE_W-1:0] xs);
        sample_pair_t p;
        p.y = ys;
        p.x = xs;
        return p;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            unit_sel <= UNIT_TURNS;
        end else if (i_cfg_wr_en) begin
            unit_sel <= i_cfg_wr_data;
        end
    end

    always @(posedge i_clk) begin : sample_driver
        sample_pair_t p;
        if (!i_rst_n) begin
            in_ch.valid    <= 1'b0;
            in_ch.y_sample <= '0;
            in_ch.x_sample <= '0;
            src_gap        <= 0;
        end else if (in_ch.valid && !in_ch.ready) begin
        end else if (src_gap != 0) begin
            in_ch.valid <= 1'b0;
            src_gap     <= src_gap - 1;
        end else if (pair_q.size() != 0) begin
            if (idle_on && $urandom_range(0, 5) == 0) begin
                in_ch.valid <= 1'b0;
                src_gap     <= $urandom_range(0, 3);
            end else begin
                p = pair_q.pop_front();
                in_ch.valid    <= 1'b1;
                in_ch.y_sample <= p.y;
                in_ch.x_sample <= p.x;
            end
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            snk_gap      <= 0;
        end else if (snk_gap != 0) begin
            out_ch.ready <= 1'b0;
            snk_gap      <= snk_gap - 1;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            out_ch.ready <= 1'b0;
            snk_gap      <= $urandom_range(0, 3);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : sample_monitor
        angle_expect_t e;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            e.y     = in_ch.y_sample;
            e.x     = in_ch.x_sample;
            e.unit  = unit_sel;
            e.angle = predict_angle(in_ch.y_sample, in_ch.x_sample, unit_sel);
            expected_angles.push_back(e);
        end
    end

    always @(posedge i_clk) begin : angle_monitor
        angle_expect_t e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_angles.size() == 0) begin
                flag_mismatch($sformatf("unexpected transaction, angle %06h",
                                        out_ch.angle_out));
            end else begin
                e = expected_angles.pop_front();
                n_checked++;
                if (out_ch.angle_out !== e.angle) begin
                    flag_mismatch($sformatf("y=%0d x=%0d unit=%0d angle %06h, want %06h",
                                            e.y, e.x, e.unit, out_ch.angle_out, e.angle));
                end
            end
        end
    end

    task automatic wait_idle();
        while (pair_q.size() != 0 || in_ch.valid || expected_angles.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_unit(input logic [1:0] unit);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= unit;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [1:0] unit;
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = UNIT_TURNS;
        in_ch.valid    = 1'b0;
        in_ch.y_sample = '0;
        in_ch.x_sample = '0;
        out_ch.ready   = 1'b0;
        idle_on        = 1'b1;
        n_errors       = 0;
        n_checked      = 0;
        n_phases_done  = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            repeat (2) @(posedge i_clk);
            case (ph)
                0:       unit = UNIT_TURNS;
                1:       unit = UNIT_RAD;
                2:       unit = UNIT_DEG;
                3:       unit = UNIT_SPARE;
                default: unit = 2'($urandom_range(0, 3));
            endcase
            idle_on = (ph != NUM_PHASES - 1);
            write_unit(unit);
            @(posedge i_clk);

            if (ph == 0) begin
                pair_q.push_back(make_pair(24'sd0, 24'sd0));
                pair_q.push_back(make_pair(24'sd0, S_MAX));
                pair_q.push_back(make_pair(24'sd0, S_MIN));
                pair_q.push_back(make_pair(S_MAX, 24'sd0));
                pair_q.push_back(make_pair(S_MIN, 24'sd0));
                pair_q.push_back(make_pair(24'sd0, 24'sd1));
                pair_q.push_back(make_pair(24'sd0, -24'sd1));
                pair_q.push_back(make_pair(24'sd1, 24'sd0));
                pair_q.push_back(make_pair(-24'sd1, 24'sd0));
                pair_q.push_back(make_pair(S_MAX, S_MAX));
                pair_q.push_back(make_pair(S_MIN, S_MIN));
                pair_q.push_back(make_pair(S_MAX, S_MIN));
                pair_q.push_back(make_pair(S_MIN, S_MAX));
                pair_q.push_back(make_pair(24'sd1, 24'sd1));
                pair_q.push_back(make_pair(-24'sd1, -24'sd1));
                pair_q.push_back(make_pair(24'sd1, S_MIN));
                pair_q.push_back(make_pair(-24'sd1, S_MIN));
                pair_q.push_back(make_pair(24'sd1, S_MAX));
                pair_q.push_back(make_pair(S_MIN, -24'sd1));
                pair_q.push_back(make_pair(S_MAX, 24'sd1));
                pair_q.push_back(make_pair(24'sh555555, -24'sh2AAAAB));
            end
            // Two angles just below the full circle, where rounding can wrap to zero, then the negative x and y axes.
            pair_q.push_back(make_pair(-24'sd1, S_MAX));
            pair_q.push_back(make_pair(-24'sd1, 24'sh400000));
            pair_q.push_back(make_pair(24'sd0, S_MIN));
            pair_q.push_back(make_pair(S_MIN, 24'sd0));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pair_q.push_back(random_pair());
            end
            n_phases_done++;
        end

        wait_idle();
        repeat (CORE_DELAY + 8) @(posedge i_clk);
        $display("Checked %0d angles over %0d unit settings, including all four unit codes.",
                 n_checked, n_phases_done);
        $display("Stimulus covered axes, origin, range corners and near-wrap angles.");
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("Timeout with %0d angles still outstanding.", expected_angles.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
hw/rtl/fca_pkg.sv
hw/rtl/fca_if.sv
hw/rtl/fca_cell.sv
hw/rtl/fca_scale.sv
hw/rtl/full_circle_atan2_angle_core.sv
test/full_circle_atan2_angle_core_tb.sv
